### design/msdec_pkg.sv
// Shared types and tag codes for the MessagePack subset token decoder.
`default_nettype none

package msdec_pkg;

    // Kind of a result item.
    typedef enum logic [2:0] {
        K_UINT  = 3'd0,
        K_NIL   = 3'd1,
        K_BIN   = 3'd2,
        K_STR   = 3'd3,
        K_ARRAY = 3'd4,
        K_MAP   = 3'd5,
        K_BYTE  = 3'd6
    } t_kind;

    // Status of a result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    // Tags that open a multi-byte header, and nil.
    localparam logic [7:0] TAG_NIL   = 8'hC0;
    localparam logic [7:0] TAG_BIN8  = 8'hC4;
    localparam logic [7:0] TAG_BIN16 = 8'hC5;
    localparam logic [7:0] TAG_BIN32 = 8'hC6;
    localparam logic [7:0] TAG_UINT8 = 8'hCC;
    localparam logic [7:0] TAG_UINT16 = 8'hCD;
    localparam logic [7:0] TAG_UINT32 = 8'hCE;
    localparam logic [7:0] TAG_STR8  = 8'hD9;
    localparam logic [7:0] TAG_STR16 = 8'hDA;
    localparam logic [7:0] TAG_STR32 = 8'hDB;
    localparam logic [7:0] TAG_ARR16 = 8'hDC;
    localparam logic [7:0] TAG_MAP16 = 8'hDE;

    // One input byte as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    // One result item.
    typedef struct packed {
        t_kind       token_kind;
        logic [31:0] token_value;
        logic [7:0]  payload_byte;
        t_status     status;
        logic        buffer_done;
    } t_result;

endpackage

`default_nettype wire

### design/msdec_in_stage.sv
// Input register of the decoder: holds one byte transfer until the core takes it.
`default_nettype none

module msdec_in_stage
    import msdec_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    input  wire logic       i_advance,
    output logic            o_valid,
    output t_in_item        o_item
);

    logic     r_valid;
    t_in_item r_item;

    // The register is free when empty or when its byte moves on this cycle.
    assign o_s_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.data_byte     <= i_data_byte;
            r_item.end_of_buffer <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### design/msdec_core.sv
// Decoder state and the per-byte tag, header and payload logic.
`default_nettype none

module msdec_core
    import msdec_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_advance,
    input  wire t_in_item i_item,
    output logic          o_has_result,
    output t_result       o_result
);

    typedef enum logic [2:0] {
        PH_TAG = 3'b001,
        PH_HDR = 3'b010,
        PH_PAY = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_left, n_hdr_left;
    logic [31:0] r_hdr_acc, n_hdr_acc;
    t_kind       r_pend_kind, n_pend_kind;
    logic [31:0] r_pay_left, n_pay_left;
    logic        r_drop, n_drop;

    always_comb begin
        logic [7:0]  b;
        logic        eob;
        logic        fin_en;
        t_kind       fin_kind;
        logic [31:0] fin_value;
        logic        op_en;
        t_kind       op_kind;
        logic [2:0]  op_nb;
        logic [31:0] acc;
        logic [31:0] pay_dec;

        b         = i_item.data_byte;
        eob       = i_item.end_of_buffer;
        fin_en    = 1'b0;
        fin_kind  = K_UINT;
        fin_value = 32'd0;
        op_en     = 1'b0;
        op_kind   = K_UINT;
        op_nb     = 3'd0;
        acc       = {r_hdr_acc[23:0], b};
        pay_dec   = r_pay_left - 32'd1;

        n_phase     = r_phase;
        n_hdr_left  = r_hdr_left;
        n_hdr_acc   = r_hdr_acc;
        n_pend_kind = r_pend_kind;
        n_pay_left  = r_pay_left;
        n_drop      = r_drop;

        o_has_result         = 1'b1;
        o_result.token_kind  = K_UINT;
        o_result.token_value = 32'd0;
        o_result.payload_byte = 8'd0;
        o_result.status      = ST_OK;
        o_result.buffer_done = eob;

        if (r_drop) begin
            o_has_result = 1'b0;
        end else begin
            unique case (r_phase)
                PH_HDR: begin
                    n_hdr_acc = acc;
                    if (r_hdr_left <= 3'd1) begin
                        n_hdr_left = 3'd0;
                        fin_en     = 1'b1;
                        fin_kind   = r_pend_kind;
                        fin_value  = acc;
                    end else begin
                        n_hdr_left = r_hdr_left - 3'd1;
                        if (eob) begin
                            o_result.token_kind = r_pend_kind;
                            o_result.status     = ST_TRUNC;
                        end else begin
                            o_has_result = 1'b0;
                        end
                    end
                end
                PH_PAY: begin
                    n_pay_left = pay_dec;
                    if (pay_dec == 32'd0) begin
                        n_phase = PH_TAG;
                    end
                    o_result.token_kind   = K_BYTE;
                    o_result.payload_byte = b;
                    if (eob && pay_dec != 32'd0) begin
                        o_result.status = ST_TRUNC;
                    end
                end
                default: begin
                    unique case (b) inside
                        [8'h00:8'h7F]: begin
                            fin_en = 1'b1; fin_kind = K_UINT; fin_value = {24'd0, b};
                        end
                        [8'h80:8'h8F]: begin
                            fin_en = 1'b1; fin_kind = K_MAP; fin_value = {28'd0, b[3:0]};
                        end
                        [8'h90:8'h9F]: begin
                            fin_en = 1'b1; fin_kind = K_ARRAY; fin_value = {28'd0, b[3:0]};
                        end
                        [8'hA0:8'hBF]: begin
                            fin_en = 1'b1; fin_kind = K_STR; fin_value = {27'd0, b[4:0]};
                        end
                        TAG_NIL: begin
                            fin_en = 1'b1; fin_kind = K_NIL;
                        end
                        TAG_UINT8:  begin op_en = 1'b1; op_kind = K_UINT;  op_nb = 3'd1; end
                        TAG_UINT16: begin op_en = 1'b1; op_kind = K_UINT;  op_nb = 3'd2; end
                        TAG_UINT32: begin op_en = 1'b1; op_kind = K_UINT;  op_nb = 3'd4; end
                        TAG_BIN8:   begin op_en = 1'b1; op_kind = K_BIN;   op_nb = 3'd1; end
                        TAG_BIN16:  begin op_en = 1'b1; op_kind = K_BIN;   op_nb = 3'd2; end
                        TAG_BIN32:  begin op_en = 1'b1; op_kind = K_BIN;   op_nb = 3'd4; end
                        TAG_STR8:   begin op_en = 1'b1; op_kind = K_STR;   op_nb = 3'd1; end
                        TAG_STR16:  begin op_en = 1'b1; op_kind = K_STR;   op_nb = 3'd2; end
                        TAG_STR32:  begin op_en = 1'b1; op_kind = K_STR;   op_nb = 3'd4; end
                        TAG_ARR16:  begin op_en = 1'b1; op_kind = K_ARRAY; op_nb = 3'd2; end
                        TAG_MAP16:  begin op_en = 1'b1; op_kind = K_MAP;   op_nb = 3'd2; end
                        default: begin
                            o_result.status = ST_BAD;
                            n_drop          = 1'b1;
                        end
                    endcase

                    if (op_en) begin
                        n_phase     = PH_HDR;
                        n_pend_kind = op_kind;
                        n_hdr_left  = op_nb;
                        n_hdr_acc   = 32'd0;
                        if (eob) begin
                            o_result.token_kind = op_kind;
                            o_result.status     = ST_TRUNC;
                        end else begin
                            o_has_result = 1'b0;
                        end
                    end
                end
            endcase

            // A completed header emits its token; bin and str with a length open a payload.
            if (fin_en) begin
                o_result.token_kind  = fin_kind;
                o_result.token_value = fin_value;
                if ((fin_kind == K_BIN || fin_kind == K_STR) && fin_value != 32'd0) begin
                    n_phase    = PH_PAY;
                    n_pay_left = fin_value;
                    if (eob) begin
                        o_result.status = ST_TRUNC;
                    end
                end else begin
                    n_phase = PH_TAG;
                end
            end
        end

        // The final byte of a buffer always returns the decoder to its reset state.
        if (eob) begin
            n_phase     = PH_TAG;
            n_hdr_left  = 3'd0;
            n_hdr_acc   = 32'd0;
            n_pend_kind = K_UINT;
            n_pay_left  = 32'd0;
            n_drop      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_hdr_left  <= 3'd0;
            r_hdr_acc   <= 32'd0;
            r_pend_kind <= K_UINT;
            r_pay_left  <= 32'd0;
            r_drop      <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_hdr_left  <= n_hdr_left;
            r_hdr_acc   <= n_hdr_acc;
            r_pend_kind <= n_pend_kind;
            r_pay_left  <= n_pay_left;
            r_drop      <= n_drop;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.end_of_buffer |=>
            r_phase == PH_TAG && !r_drop && r_hdr_left == 3'd0 && r_pay_left == 32'd0)
        else $error("state not cleared after the final byte of a buffer");

    a_pay_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_pay_left != 32'd0)
        else $error("payload phase with no payload bytes owed");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HDR |-> r_hdr_left != 3'd0 && r_hdr_left <= 3'd4)
        else $error("header phase with an impossible byte count");

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> !o_has_result && r_phase == PH_TAG)
        else $error("result produced while dropping after a bad tag");
`endif

endmodule

`default_nettype wire

### design/msdec_out_stage.sv
// Result register of the decoder, driving the master-side stream.
`default_nettype none

module msdec_out_stage
    import msdec_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_advance,
    input  wire logic    i_has_result,
    input  wire t_result i_result,
    input  wire logic    i_m_tready,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_has_result;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### design/msgpack_subset_token_decoder.sv
// Top level of the MessagePack subset token decoder.
`default_nettype none

// Takes one byte of an encoded buffer per transfer, with tlast on the final
// byte, and returns at most one result transfer per byte: a token when its
// header completes, then each bin or str payload byte in turn. A bad tag gives
// one result and the rest of that buffer is dropped silently; a buffer that
// ends inside a header or payload gives a result with the truncated status.
// One byte is taken every clock cycle while the result side keeps up; the
// rate is set by the single decode step between the input register and the
// result register. A taken byte waits in the input register, and its result
// is offered from the result register once the core has decoded it.
// No clearing pass is needed after reset.
module msgpack_subset_token_decoder
    import msdec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tlast,   // end_of_buffer
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [31:0] token_value, [39:32] payload_byte
    output logic [4:0]       o_m_tuser,   // [2:0] token_kind, [4:3] status
    output logic             o_m_tlast    // buffer_done
);

    logic     in_valid;
    t_in_item in_item;
    logic     out_valid;
    logic     advance;
    logic     has_result;
    t_result  core_result;
    t_result  out_result;

    // A byte moves into the core when the result register can take its result.
    assign advance = in_valid && (!out_valid || i_m_tready);

    msdec_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_data_byte (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_advance   (advance),
        .o_valid     (in_valid),
        .o_item      (in_item)
    );

    msdec_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (in_item),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    msdec_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_has_result (has_result),
        .i_result     (core_result),
        .i_m_tready   (i_m_tready),
        .o_valid      (out_valid),
        .o_result     (out_result)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {out_result.payload_byte, out_result.token_value};
    assign o_m_tuser  = {out_result.status, out_result.token_kind};
    assign o_m_tlast  = out_result.buffer_done;

endmodule

`default_nettype wire

### test/msgpack_subset_token_decoder_tb.sv
// Self-checking testbench for the MessagePack subset token decoder.
`default_nettype none

module msgpack_subset_token_decoder_tb;
    import msdec_pkg::*;

    localparam int BYTE_TARGET  = 1975;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SCRIPT_ROWS  = 25;

    typedef enum logic [1:0] {
        AWAIT_TAG  = 2'd0,
        IN_HEADER  = 2'd1,
        IN_PAYLOAD = 2'd2
    } t_stage;

    // One directed byte; want is only used where fixed is set.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        t_result    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;   // [7:0] data_byte
    logic        i_s_tlast = 1'b0;   // end_of_buffer
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;          // [31:0] token_value, [39:32] payload_byte
    logic [4:0]  o_m_tuser;          // [2:0] token_kind, [4:3] status
    logic        o_m_tlast;          // buffer_done

    msgpack_subset_token_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state mirrored by the predictor.
    t_stage      stage;
    logic [2:0]  hdr_left;
    logic [31:0] hdr_acc;
    t_kind       open_kind;
    logic [31:0] pay_left;
    logic        dropping;

    t_result     token_q[$];
    logic [7:0]  frame_bytes[$];
    t_row        script[SCRIPT_ROWS];

    int n_bytes = 0;
    int n_results = 0;
    int n_tokens = 0;
    int n_payload = 0;
    int n_bad = 0;
    int n_trunc = 0;
    int n_errors = 0;
    int cycles = 0;
    logic eager = 1'b0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;

    task automatic queue_result(input t_result r);
        token_q = {token_q, r};
    endtask

    task automatic queue_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    function automatic t_result make_result(input t_kind k, input logic [31:0] v,
                                            input logic [7:0] pb, input t_status s,
                                            input logic d);
        t_result r;
        r.token_kind   = k;
        r.token_value  = v;
        r.payload_byte = pb;
        r.status       = s;
        r.buffer_done  = d;
        return r;
    endfunction

    function automatic t_row row(input logic [7:0] b, input logic last, input logic fixed,
                                 input t_kind k, input logic [31:0] v, input logic [7:0] pb,
                                 input t_status s);
        t_row x;
        x.data  = b;
        x.last  = last;
        x.fixed = fixed;
        x.want  = make_result(k, v, pb, s, last);
        return x;
    endfunction

    task automatic clear_decoder();
        stage     = AWAIT_TAG;
        hdr_left  = 3'd0;
        hdr_acc   = 32'd0;
        open_kind = K_UINT;
        pay_left  = 32'd0;
        dropping  = 1'b0;
    endtask

    // A complete header gives its token and, for a non-empty bin or str, opens the payload.
    task automatic header_done(input t_kind k, input logic [31:0] v, input logic last,
                               output t_result r);
        t_status s;
        s = ST_OK;
        if ((k == K_BIN || k == K_STR) && v != 32'd0) begin
            stage    = IN_PAYLOAD;
            pay_left = v;
            if (last)
                s = ST_TRUNC;
        end else begin
            stage = AWAIT_TAG;
        end
        r = make_result(k, v, 8'd0, s, last);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output logic got, output t_result r);
        t_kind k;
        int    nb;
        got = 1'b1;
        r   = '0;
        k   = K_UINT;
        nb  = 0;
        if (dropping) begin
            got = 1'b0;
        end else if (stage == IN_HEADER) begin
            hdr_acc = {hdr_acc[23:0], b};
            if (hdr_left <= 3'd1) begin
                hdr_left = 3'd0;
                header_done(open_kind, hdr_acc, last, r);
            end else begin
                hdr_left = hdr_left - 3'd1;
                if (last)
                    r = make_result(open_kind, 32'd0, 8'd0, ST_TRUNC, 1'b1);
                else
                    got = 1'b0;
            end
        end else if (stage == IN_PAYLOAD) begin
            pay_left = pay_left - 32'd1;
            if (pay_left == 32'd0)
                stage = AWAIT_TAG;
            r = make_result(K_BYTE, 32'd0, b,
                            (last && pay_left != 32'd0) ? ST_TRUNC : ST_OK, last);
        end else if (b < 8'h80) begin
            header_done(K_UINT, {24'd0, b}, last, r);
        end else if (b <= 8'h8F) begin
            header_done(K_MAP, {28'd0, b[3:0]}, last, r);
        end else if (b <= 8'h9F) begin
            header_done(K_ARRAY, {28'd0, b[3:0]}, last, r);
        end else if (b <= 8'hBF) begin
            header_done(K_STR, {27'd0, b[4:0]}, last, r);
        end else if (b == TAG_NIL) begin
            header_done(K_NIL, 32'd0, last, r);
        end else begin
            case (b)
                TAG_UINT8:  begin k = K_UINT;  nb = 1; end
                TAG_UINT16: begin k = K_UINT;  nb = 2; end
                TAG_UINT32: begin k = K_UINT;  nb = 4; end
                TAG_BIN8:   begin k = K_BIN;   nb = 1; end
                TAG_BIN16:  begin k = K_BIN;   nb = 2; end
                TAG_BIN32:  begin k = K_BIN;   nb = 4; end
                TAG_STR8:   begin k = K_STR;   nb = 1; end
                TAG_STR16:  begin k = K_STR;   nb = 2; end
                TAG_STR32:  begin k = K_STR;   nb = 4; end
                TAG_ARR16:  begin k = K_ARRAY; nb = 2; end
                TAG_MAP16:  begin k = K_MAP;   nb = 2; end
                default:    nb = 0;
            endcase
            if (nb == 0) begin
                r        = make_result(K_UINT, 32'd0, 8'd0, ST_BAD, last);
                dropping = 1'b1;
            end else begin
                stage     = IN_HEADER;
                open_kind = k;
                hdr_left  = nb[2:0];
                hdr_acc   = 32'd0;
                if (last)
                    r = make_result(k, 32'd0, 8'd0, ST_TRUNC, 1'b1);
                else
                    got = 1'b0;
            end
        end
        if (last)
            clear_decoder();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s is %h, expected %h",
                 n_results, what, got, want);
        n_errors++;
    endtask

    // Offers one byte and, once the transfer is taken, records what it should produce.
    task automatic offer(input logic [7:0] b, input logic last, input logic fixed,
                         input t_result want);
        t_result r;
        logic    got;
        if (!eager && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(b, last, got, r);
        if (fixed)
            queue_result(want);
        else if (got)
            queue_result(r);
        n_bytes++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (token_q.size() != 0);
    endtask

    task automatic put_be(input logic [31:0] v, input int nb);
        for (int i = nb - 1; i >= 0; i--)
            queue_byte(v[8*i +: 8]);
    endtask

    task automatic put_payload(input int len);
        for (int i = 0; i < len; i++)
            queue_byte(8'($urandom_range(0, 255)));
    endtask

    // Appends one well-formed token, with its payload where it has one.
    task automatic add_token();
        int          pick;
        int          nb;
        int          len;
        logic [31:0] cnt;
        pick = $urandom_range(0, 7);
        nb   = 1 << $urandom_range(0, 2);
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        cnt  = $urandom;
        case (pick)
            0: queue_byte(8'($urandom_range(0, 127)));
            1: begin
                queue_byte(nb == 1 ? TAG_UINT8 : nb == 2 ? TAG_UINT16 : TAG_UINT32);
                put_be($urandom, nb);
            end
            2: queue_byte(TAG_NIL);
            3: begin
                len = (len > 31) ? 31 : len;
                queue_byte({3'b101, len[4:0]});
                put_payload(len);
            end
            4: begin
                queue_byte(nb == 1 ? TAG_STR8 : nb == 2 ? TAG_STR16 : TAG_STR32);
                put_be(len, nb);
                put_payload(len);
            end
            5: begin
                queue_byte(nb == 1 ? TAG_BIN8 : nb == 2 ? TAG_BIN16 : TAG_BIN32);
                put_be(len, nb);
                put_payload(len);
            end
            6: queue_byte({3'b100, cnt[4], cnt[3:0]});
            default: begin
                queue_byte(cnt[16] ? TAG_ARR16 : TAG_MAP16);
                put_be(cnt, 2);
            end
        endcase
    endtask

    function automatic logic [7:0] pick_bad_tag();
        logic [7:0] t;
        logic       found;
        t     = 8'hC1;
        found = 1'b0;
        while (!found) begin
            t     = 8'($urandom_range(8'hC1, 8'hFF));
            found = 1'b1;
            case (t)
                TAG_NIL, TAG_BIN8, TAG_BIN16, TAG_BIN32, TAG_UINT8, TAG_UINT16,
                TAG_UINT32, TAG_STR8, TAG_STR16, TAG_STR32, TAG_ARR16, TAG_MAP16:
                    found = 1'b0;
                default: ;
            endcase
        end
        return t;
    endfunction

    // Builds one buffer and sends its first keep bytes, tlast on the final one.
    task automatic send_buffer();
        int style;
        int keep;
        frame_bytes.delete();
        style = $urandom_range(0, 9);
        if (style <= 5) begin
            repeat ($urandom_range(1, 5)) add_token();
        end else if (style == 6) begin
            repeat ($urandom_range(1, 4)) add_token();
        end else if (style == 7) begin
            // A huge length that the buffer can never satisfy.
            queue_byte($urandom_range(0, 1) ? TAG_STR32 : TAG_BIN32);
            put_be($urandom, 4);
            put_payload($urandom_range(0, 3));
        end else if (style == 8) begin
            repeat ($urandom_range(0, 2)) add_token();
            queue_byte(pick_bad_tag());
            repeat ($urandom_range(0, 3)) add_token();
        end else begin
            put_payload($urandom_range(1, 8));
        end
        keep = (style == 6) ? $urandom_range(1, frame_bytes.size()) : frame_bytes.size();
        for (int i = 0; i < keep; i++)
            offer(frame_bytes[i], i == keep - 1, 1'b0, '0);
    endtask

    // Result side: random stall bursts, quiet runs, and one long hold on request.
    int stall_left = 0;
    int run_left = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_left  <= HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else if (calm) begin
            i_m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (run_left != 0) begin
            run_left   <= run_left - 1;
            i_m_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 19) == 0)
                run_left <= $urandom_range(30, 80);
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (token_q.size() == 0) begin
                report_mismatch("unexpected transfer, value", o_m_tdata[31:0], 32'd0);
            end else begin
                want = token_q.pop_front();
                if (o_m_tuser[2:0] !== want.token_kind)
                    report_mismatch("token_kind", 32'(o_m_tuser[2:0]),
                                    32'(want.token_kind));
                if (o_m_tdata[31:0] !== want.token_value)
                    report_mismatch("token_value", o_m_tdata[31:0], want.token_value);
                if (o_m_tdata[39:32] !== want.payload_byte)
                    report_mismatch("payload_byte", 32'(o_m_tdata[39:32]),
                                    32'(want.payload_byte));
                if (o_m_tuser[4:3] !== want.status)
                    report_mismatch("status", 32'(o_m_tuser[4:3]), 32'(want.status));
                if (o_m_tlast !== want.buffer_done)
                    report_mismatch("buffer_done", 32'(o_m_tlast), 32'(want.buffer_done));
                if (want.token_kind == K_BYTE)
                    n_payload++;
                else
                    n_tokens++;
                if (want.status == ST_BAD)
                    n_bad++;
                if (want.status == ST_TRUNC)
                    n_trunc++;
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results pending",
                     cycles, token_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        clear_decoder();
        script[0]  = row(8'h00, 1'b0, 1'b1, K_UINT,  32'd0,        8'h00, ST_OK);
        script[1]  = row(8'h7F, 1'b0, 1'b1, K_UINT,  32'h7F,       8'h00, ST_OK);
        script[2]  = row(8'hC0, 1'b0, 1'b1, K_NIL,   32'd0,        8'h00, ST_OK);
        script[3]  = row(8'h8F, 1'b0, 1'b1, K_MAP,   32'd15,       8'h00, ST_OK);
        script[4]  = row(8'h90, 1'b0, 1'b1, K_ARRAY, 32'd0,        8'h00, ST_OK);
        script[5]  = row(8'hA2, 1'b0, 1'b1, K_STR,   32'd2,        8'h00, ST_OK);
        script[6]  = row(8'hAA, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[7]  = row(8'h55, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[8]  = row(8'hCE, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[9]  = row(8'hFF, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[10] = row(8'hFF, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[11] = row(8'hFF, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[12] = row(8'hFF, 1'b0, 1'b1, K_UINT,  32'hFFFFFFFF, 8'h00, ST_OK);
        script[13] = row(8'hDC, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[14] = row(8'hAB, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[15] = row(8'hCD, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        // Buffer ends on a header tag, then one ends inside a str payload.
        script[16] = row(8'hC6, 1'b1, 1'b1, K_BIN,   32'd0,        8'h00, ST_TRUNC);
        script[17] = row(8'hD9, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[18] = row(8'h05, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[19] = row(8'h01, 1'b1, 1'b1, K_BYTE,  32'd0,        8'h01, ST_TRUNC);
        // Bad tag: the rest of the buffer, its final byte too, is dropped.
        script[20] = row(8'hC1, 1'b0, 1'b1, K_UINT,  32'd0,        8'h00, ST_BAD);
        script[21] = row(8'h00, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[22] = row(8'hFF, 1'b1, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[23] = row(8'hDE, 1'b0, 1'b0, K_UINT,  32'd0,        8'h00, ST_OK);
        script[24] = row(8'h01, 1'b1, 1'b1, K_MAP,   32'd0,        8'h00, ST_TRUNC);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++)
            offer(script[i].data, script[i].last, script[i].fixed, script[i].want);
        drain();

        while (n_bytes < 700)
            send_buffer();
        drain();

        // Long hold on the result side while bytes keep coming, so the input stalls.
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        eager = 1'b1;
        while (n_bytes < 820)
            send_buffer();
        eager = 1'b0;

        while (n_bytes < 1500)
            send_buffer();
        drain();

        calm  <= 1'b1;
        eager = 1'b1;
        while (n_bytes < BYTE_TARGET)
            send_buffer();
        drain();
        repeat (20) @(posedge i_clk);

        $display("%0d bytes sent in %0d cycles; %0d results checked (%0d tokens, %0d payload)",
                 n_bytes, cycles, n_results, n_tokens, n_payload);
        $display("%0d bad-tag and %0d truncated results seen; %0d mismatches",
                 n_bad, n_trunc, n_errors);
        if (n_errors == 0 && token_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
